FILE: src/adjacency_to_incidence_edges_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the adjacency to incidence edge block
// Shared helpers for the concurrent checks in the checker module.
// ----------------------------------------------------------------------------
`ifndef ADJACENCY_TO_INCIDENCE_EDGES_DEFINES_SVH
`define ADJACENCY_TO_INCIDENCE_EDGES_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ADJINC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adjinc check failed");

// Consequent must hold in the cycle after the antecedent.
`define ADJINC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adjinc check failed");

`endif

FILE: src/adjinc_pkg.sv
// ----------------------------------------------------------------------------
// adjinc_pkg
// Types and constants shared by the controller, datapath and checker.
// ----------------------------------------------------------------------------
package adjinc_pkg;

  localparam int VCOUNT_W   = 4;
  localparam int VERTEX_W   = 3;
  localparam int EDGE_NUM_W = 6;
  localparam int KIND_W     = 2;

  localparam logic [KIND_W-1:0] KIND_SELF  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UNDIR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DIR   = 2'd2;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 4'd8;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SYM_RD,
    ST_SYM_CMP,
    ST_EMIT_RD,
    ST_EMIT_CHK,
    ST_FLUSH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ready;
    logic load;
    logic scan_clear;
    logic sym_rd;
    logic sym_cmp;
    logic emit_rd;
    logic emit_take;
    logic flush;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_load;
    logic scan_end;
    logic hit;
    logic pend_valid;
    logic out_free;
  } stat_t;

endpackage

FILE: src/adjinc_ram.sv
// ----------------------------------------------------------------------------
// adjinc_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module adjinc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: src/adjinc_ctrl.sv
// ----------------------------------------------------------------------------
// adjinc_ctrl
// Sequencer for load, symmetry scan, edge scan and final flush.
// ----------------------------------------------------------------------------
module adjinc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  adjinc_pkg::stat_t   stat,
  output adjinc_pkg::cmd_t    cmd
);

  adjinc_pkg::state_t state;
  adjinc_pkg::state_t state_next;
  logic               emit_wait;

  // A new edge can only displace the pending one when the output is free.
  assign emit_wait = stat.hit && stat.pend_valid && !stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= adjinc_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      adjinc_pkg::ST_LOAD: begin
        if (in_valid && stat.last_load) begin
          state_next = adjinc_pkg::ST_SYM_RD;
        end
      end
      adjinc_pkg::ST_SYM_RD: begin
        state_next = adjinc_pkg::ST_SYM_CMP;
      end
      adjinc_pkg::ST_SYM_CMP: begin
        state_next = stat.scan_end ? adjinc_pkg::ST_EMIT_RD : adjinc_pkg::ST_SYM_RD;
      end
      adjinc_pkg::ST_EMIT_RD: begin
        state_next = adjinc_pkg::ST_EMIT_CHK;
      end
      adjinc_pkg::ST_EMIT_CHK: begin
        if (!emit_wait) begin
          state_next = stat.scan_end ? adjinc_pkg::ST_FLUSH : adjinc_pkg::ST_EMIT_RD;
        end
      end
      adjinc_pkg::ST_FLUSH: begin
        if (stat.out_free) begin
          state_next = adjinc_pkg::ST_LOAD;
        end
      end
      default: state_next = adjinc_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      adjinc_pkg::ST_LOAD: begin
        cmd.ready      = 1'b1;
        cmd.load       = in_valid;
        cmd.scan_clear = in_valid && stat.last_load;
      end
      adjinc_pkg::ST_SYM_RD:   cmd.sym_rd    = 1'b1;
      adjinc_pkg::ST_SYM_CMP:  cmd.sym_cmp   = 1'b1;
      adjinc_pkg::ST_EMIT_RD:  cmd.emit_rd   = 1'b1;
      adjinc_pkg::ST_EMIT_CHK: cmd.emit_take = !emit_wait;
      adjinc_pkg::ST_FLUSH:    cmd.flush     = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: src/adjinc_dp.sv
// ----------------------------------------------------------------------------
// adjinc_dp
// Matrix store, scan counters, pending edge and output register.
// ----------------------------------------------------------------------------
module adjinc_dp #(
  parameter int MAX_VERTICES = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 config_write,
  input  logic [adjinc_pkg::VCOUNT_W-1:0]      config_data,
  input  logic                                 adjacency_entry,
  input  adjinc_pkg::cmd_t                     cmd,
  output adjinc_pkg::stat_t                    stat,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic                                 edge_valid,
  output logic [adjinc_pkg::EDGE_NUM_W-1:0]    edge_number,
  output logic [adjinc_pkg::VERTEX_W-1:0]      first_vertex,
  output logic [adjinc_pkg::VERTEX_W-1:0]      second_vertex,
  output logic [adjinc_pkg::KIND_W-1:0]        edge_kind,
  output logic                                 graph_directed,
  output logic                                 last_edge
);

  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [adjinc_pkg::VCOUNT_W-1:0]   vertex_count;
  logic [adjinc_pkg::VCOUNT_W-1:0]   n;
  logic [adjinc_pkg::VCOUNT_W-1:0]   n_m1;
  logic [7:0]                        total_m1;
  logic [CW-1:0]                     load_count;
  logic [adjinc_pkg::VERTEX_W-1:0]   i;
  logic [adjinc_pkg::VERTEX_W-1:0]   j;
  logic                              j_end;
  logic                              i_end;
  logic [6:0]                        addr_ij;
  logic [6:0]                        addr_ji;
  logic                              rdata_a;
  logic                              rdata_b;
  logic                              directed;
  logic                              hit;
  logic [adjinc_pkg::KIND_W-1:0]     kind;
  logic                              pend_valid;
  logic [adjinc_pkg::EDGE_NUM_W-1:0] pend_num;
  logic [adjinc_pkg::VERTEX_W-1:0]   pend_i;
  logic [adjinc_pkg::VERTEX_W-1:0]   pend_j;
  logic [adjinc_pkg::KIND_W-1:0]     pend_kind;
  logic [adjinc_pkg::EDGE_NUM_W-1:0] edge_count;
  logic                              out_free;

  // Zero acts as one vertex, anything above the maximum as the maximum.
  always_comb begin
    if (vertex_count == '0) begin
      n = adjinc_pkg::VCOUNT_W'(1);
    end else if (vertex_count > adjinc_pkg::VCOUNT_W'(MAX_VERTICES)) begin
      n = adjinc_pkg::VCOUNT_W'(MAX_VERTICES);
    end else begin
      n = vertex_count;
    end
  end

  assign n_m1     = n - adjinc_pkg::VCOUNT_W'(1);
  assign total_m1 = 8'(n * n) - 8'd1;
  assign j_end    = ({1'b0, j} == n_m1);
  assign i_end    = ({1'b0, i} == n_m1);
  assign addr_ij  = 7'(i) * 7'(n) + 7'(j);
  assign addr_ji  = 7'(j) * 7'(n) + 7'(i);

  adjinc_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (cmd.load),
    .waddr   (load_count[AW-1:0]),
    .wdata   (adjacency_entry),
    .re_a    (cmd.sym_rd || cmd.emit_rd),
    .raddr_a (addr_ij[AW-1:0]),
    .rdata_a (rdata_a),
    .re_b    (cmd.sym_rd),
    .raddr_b (addr_ji[AW-1:0]),
    .rdata_b (rdata_b)
  );

  // In an undirected graph only the lower triangle and the diagonal count.
  assign hit = rdata_a && ((i == j) || directed || (i > j));

  always_comb begin
    if (i == j) begin
      kind = adjinc_pkg::KIND_SELF;
    end else if (directed) begin
      kind = adjinc_pkg::KIND_DIR;
    end else begin
      kind = adjinc_pkg::KIND_UNDIR;
    end
  end

  assign out_free = !out_valid || !out_stall;

  assign stat.last_load  = (8'(load_count) == total_m1);
  assign stat.scan_end   = i_end && j_end;
  assign stat.hit        = hit;
  assign stat.pend_valid = pend_valid;
  assign stat.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= adjinc_pkg::VCOUNT_RESET;
      load_count   <= '0;
    end else if (config_write) begin
      vertex_count <= config_data;
      load_count   <= '0;
    end else if (cmd.load) begin
      load_count <= stat.last_load ? '0 : load_count + CW'(1);
    end
  end

  // Row-major scan counters, shared by the symmetry and edge scans.
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_clear) begin
      i <= '0;
      j <= '0;
    end else if (cmd.sym_cmp || cmd.emit_take) begin
      if (j_end) begin
        j <= '0;
        i <= i_end ? '0 : i + adjinc_pkg::VERTEX_W'(1);
      end else begin
        j <= j + adjinc_pkg::VERTEX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.scan_clear) begin
      directed <= 1'b0;
    end else if (cmd.sym_cmp && (rdata_a != rdata_b)) begin
      directed <= 1'b1;
    end
  end

  // One edge is held back so that the final one can be marked as last.
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_clear) begin
      pend_valid <= 1'b0;
      edge_count <= '0;
    end else if (cmd.emit_take && hit) begin
      pend_valid <= 1'b1;
      edge_count <= edge_count + adjinc_pkg::EDGE_NUM_W'(1);
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_take && hit) begin
      pend_num  <= edge_count;
      pend_i    <= i;
      pend_j    <= j;
      pend_kind <= kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.emit_take && hit && pend_valid) || cmd.flush) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_take && hit && pend_valid) begin
      edge_valid     <= 1'b1;
      edge_number    <= pend_num;
      first_vertex   <= pend_i;
      second_vertex  <= pend_j;
      edge_kind      <= pend_kind;
      graph_directed <= directed;
      last_edge      <= 1'b0;
    end else if (cmd.flush) begin
      edge_valid     <= pend_valid;
      edge_number    <= pend_valid ? pend_num : '0;
      first_vertex   <= pend_valid ? pend_i : '0;
      second_vertex  <= pend_valid ? pend_j : '0;
      edge_kind      <= pend_valid ? pend_kind : adjinc_pkg::KIND_SELF;
      graph_directed <= pend_valid && directed;
      last_edge      <= 1'b1;
    end
  end

endmodule

FILE: src/adjacency_to_incidence_edges.sv
// ----------------------------------------------------------------------------
// adjacency_to_incidence_edges
// Turns a streamed adjacency matrix into a list of incidence-matrix rows.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one adjacency bit per request, row-major, for
//   n*n requests, where n is the clamped vertex count from the config port.
//   A load takes one bit per cycle. After the last bit the input is stalled
//   while the block checks symmetry (a read and a compare per matrix entry,
//   one pass of the two read ports of the matrix store), then scans for
//   edges (one read of the store and a check per entry) and at last flushes
//   the pending edge; a stalling receiver holds up the scan and the flush.
//   Each edge is one output request; the last one of a run has last_edge
//   set, and an empty graph gives a single request with edge_valid low.
//   One edge is held back in a pending register so that the final one can
//   be marked; a stalled output holds its request, and the scan waits when it finds a further edge.
//   Reset returns the vertex count to 8 and clears the load position; the
//   matrix store needs no clearing, as every entry is written before use.
//   Writing the vertex count restarts a partial load.
// ----------------------------------------------------------------------------
module adjacency_to_incidence_edges #(
  parameter int MAX_VERTICES = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 config_write,
  input  logic [adjinc_pkg::VCOUNT_W-1:0]      config_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 adjacency_entry,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 edge_valid,
  output logic [adjinc_pkg::EDGE_NUM_W-1:0]    edge_number,
  output logic [adjinc_pkg::VERTEX_W-1:0]      first_vertex,
  output logic [adjinc_pkg::VERTEX_W-1:0]      second_vertex,
  output logic [adjinc_pkg::KIND_W-1:0]        edge_kind,
  output logic                                 graph_directed,
  output logic                                 last_edge
);

  adjinc_pkg::cmd_t  cmd;
  adjinc_pkg::stat_t stat;

  assign in_stall = !cmd.ready;

  adjinc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  adjinc_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .config_write    (config_write),
    .config_data     (config_data),
    .adjacency_entry (adjacency_entry),
    .cmd             (cmd),
    .stat            (stat),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .edge_valid      (edge_valid),
    .edge_number     (edge_number),
    .first_vertex    (first_vertex),
    .second_vertex   (second_vertex),
    .edge_kind       (edge_kind),
    .graph_directed  (graph_directed),
    .last_edge       (last_edge)
  );

endmodule

FILE: src/adjinc_chk.sv
// ----------------------------------------------------------------------------
// adjinc_chk
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "adjacency_to_incidence_edges_defines.svh"

module adjinc_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              config_write,
  input logic [adjinc_pkg::VCOUNT_W-1:0]   config_data,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              adjacency_entry,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              edge_valid,
  input logic [adjinc_pkg::EDGE_NUM_W-1:0] edge_number,
  input logic [adjinc_pkg::VERTEX_W-1:0]   first_vertex,
  input logic [adjinc_pkg::VERTEX_W-1:0]   second_vertex,
  input logic [adjinc_pkg::KIND_W-1:0]     edge_kind,
  input logic                              graph_directed,
  input logic                              last_edge
);

  // A stalled result holds still.
  `ADJINC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(edge_number) && $stable(first_vertex) && $stable(last_edge))

  // The empty-graph result is the only one of its run and carries zeros.
  `ADJINC_ASSERT_SAME(a_empty_result, out_valid && !edge_valid, last_edge && edge_number == '0 && !graph_directed && edge_kind == adjinc_pkg::KIND_SELF)

  // Undirected edges come only from the lower triangle of a symmetric matrix.
  `ADJINC_ASSERT_SAME(a_undir_edge, out_valid && edge_valid && edge_kind == adjinc_pkg::KIND_UNDIR, !graph_directed && first_vertex > second_vertex)

  // While a run is still being emitted, no new matrix bit is taken.
  `ADJINC_ASSERT_SAME(a_no_load_mid_run, out_valid && edge_valid && !last_edge, in_stall)

endmodule

bind adjacency_to_incidence_edges adjinc_chk u_chk (.*);

FILE: verif/adjacency_to_incidence_edges_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Incidence row checker for adjacency_to_incidence_edges
// Watches the config port and both channels. It keeps its own copy of the
// loaded matrix and the vertex count, and it predicts the incidence rows
// of each completed matrix. Each output request is compared with them in
// order.
// ----------------------------------------------------------------------------
module adjacency_to_incidence_edges_checker
  import adjinc_pkg::*;
#(
  parameter int MAX_VERTICES = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  config_write,
  input  logic [VCOUNT_W-1:0]   config_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  adjacency_entry,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  edge_valid,
  input  logic [EDGE_NUM_W-1:0] edge_number,
  input  logic [VERTEX_W-1:0]   first_vertex,
  input  logic [VERTEX_W-1:0]   second_vertex,
  input  logic [KIND_W-1:0]     edge_kind,
  input  logic                  graph_directed,
  input  logic                  last_edge,
  output int                    mismatches,
  output int                    rows_pending
);

  typedef struct packed {
    logic                  is_edge;
    logic [EDGE_NUM_W-1:0] number;
    logic [VERTEX_W-1:0]   row_vertex;
    logic [VERTEX_W-1:0]   col_vertex;
    logic [KIND_W-1:0]     kind;
    logic                  directed;
    logic                  last;
  } incidence_row_t;

  incidence_row_t      incidence_rows_due[$];
  incidence_row_t      due_row;
  logic                adjacency_bits [MAX_VERTICES*MAX_VERTICES];
  logic [VCOUNT_W-1:0] vertex_count;
  int                  load_pos;

  initial begin
    mismatches   = 0;
    rows_pending = 0;
    vertex_count = VCOUNT_RESET;
    load_pos     = 0;
  end

  function automatic int active_side(input logic [VCOUNT_W-1:0] count);
    if (count == 0) return 1;
    if (count > MAX_VERTICES) return MAX_VERTICES;
    return int'(count);
  endfunction

  // Rows come out in row-major scan order. Undirected pairs appear once, on
  // the lower triangle, and a graph with no edges yields a single non-edge row.
  task automatic predict_incidence_rows();
    int                  n;
    int                  count;
    logic                directed;
    logic [KIND_W-1:0]   kind;
    logic                keep;
    incidence_row_t      row;
    n        = active_side(vertex_count);
    count    = 0;
    directed = 1'b0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (adjacency_bits[i*n+j] != adjacency_bits[j*n+i]) directed = 1'b1;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        keep = adjacency_bits[i*n+j];
        if (i == j) begin
          kind = KIND_SELF;
        end else if (!directed) begin
          kind = KIND_UNDIR;
          if (i < j) keep = 1'b0;
        end else begin
          kind = KIND_DIR;
        end
        if (keep) begin
          row = '{1'b1, EDGE_NUM_W'(count), VERTEX_W'(i), VERTEX_W'(j), kind,
                  directed, 1'b0};
          incidence_rows_due.push_back(row);
          count++;
        end
      end
    end
    if (count == 0) begin
      incidence_rows_due.push_back('{1'b0, '0, '0, '0, KIND_SELF, 1'b0, 1'b1});
    end else begin
      incidence_rows_due[incidence_rows_due.size()-1].last = 1'b1;
    end
  endtask

  task automatic check_field(input string label, input int expected, input int actual);
    if (expected != actual) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, expected, actual);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      vertex_count = VCOUNT_RESET;
      load_pos     = 0;
      incidence_rows_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (incidence_rows_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual edge_valid %0b number %0d",
                   $time, edge_valid, edge_number);
        end else begin
          due_row = incidence_rows_due.pop_front();
          check_field("edge_valid", due_row.is_edge, edge_valid);
          check_field("edge_number", due_row.number, edge_number);
          check_field("first_vertex", due_row.row_vertex, first_vertex);
          check_field("second_vertex", due_row.col_vertex, second_vertex);
          check_field("edge_kind", due_row.kind, edge_kind);
          check_field("graph_directed", due_row.directed, graph_directed);
          check_field("last_edge", due_row.last, last_edge);
        end
      end
      // A new vertex count throws away any partly loaded matrix.
      if (config_write) begin
        vertex_count = config_data;
        load_pos     = 0;
      end
      if (in_valid && !in_stall) begin
        adjacency_bits[load_pos] = adjacency_entry;
        load_pos++;
        if (load_pos >= active_side(vertex_count) * active_side(vertex_count)) begin
          load_pos = 0;
          predict_incidence_rows();
        end
      end
    end
    rows_pending = incidence_rows_due.size();
  end

endmodule

FILE: verif/adjacency_to_incidence_edges_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for adjacency_to_incidence_edges
// Streams adjacency matrices of many sizes and shapes through the block under
// varying sender gaps and receiver stalls, changing the vertex count between
// runs. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module adjacency_to_incidence_edges_tb;
  import adjinc_pkg::*;

  localparam int MAX_VERTICES  = 8;
  localparam int SETTLE_CYCLES = 4 * MAX_VERTICES * MAX_VERTICES + 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 95;
  localparam int GAP_PLAN   [3] = '{24, 88, 0};
  localparam int STALL_PLAN [3] = '{88, 24, 0};

  typedef enum {FILL_RANDOM, FILL_SYMMETRIC, FILL_EMPTY, FILL_ONES, FILL_ONES_BUT_ONE} fill_t;

  logic                  clk;
  logic                  rst;
  logic                  config_write;
  logic [VCOUNT_W-1:0]   config_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  adjacency_entry;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  edge_valid;
  logic [EDGE_NUM_W-1:0] edge_number;
  logic [VERTEX_W-1:0]   first_vertex;
  logic [VERTEX_W-1:0]   second_vertex;
  logic [KIND_W-1:0]     edge_kind;
  logic                  graph_directed;
  logic                  last_edge;

  int   mismatches;
  int   rows_pending;
  int   gap_pct   = 0;
  int   stall_pct = 0;
  int   side      = MAX_VERTICES;
  logic pressure_req  = 1'b0;
  logic pressure_seen = 1'b0;

  adjacency_to_incidence_edges #(
    .MAX_VERTICES(MAX_VERTICES)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .config_write   (config_write),
    .config_data    (config_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .adjacency_entry(adjacency_entry),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .edge_valid     (edge_valid),
    .edge_number    (edge_number),
    .first_vertex   (first_vertex),
    .second_vertex  (second_vertex),
    .edge_kind      (edge_kind),
    .graph_directed (graph_directed),
    .last_edge      (last_edge)
  );

  adjacency_to_incidence_edges_checker #(
    .MAX_VERTICES(MAX_VERTICES)
  ) row_check (
    .clk            (clk),
    .rst            (rst),
    .config_write   (config_write),
    .config_data    (config_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .adjacency_entry(adjacency_entry),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .edge_valid     (edge_valid),
    .edge_number    (edge_number),
    .first_vertex   (first_vertex),
    .second_vertex  (second_vertex),
    .edge_kind      (edge_kind),
    .graph_directed (graph_directed),
    .last_edge      (last_edge),
    .mismatches     (mismatches),
    .rows_pending   (rows_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver. A toggle of pressure_req starts one long hold-off.
  initial begin
    forever begin
      @(posedge clk);
      if (pressure_req != pressure_seen) begin
        pressure_seen = pressure_req;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Offers one matrix bit and returns at the edge where the request is taken.
  task automatic offer_entry(input logic bit_value);
    while ($urandom_range(99) < gap_pct) begin
      in_valid        <= 1'b0;
      adjacency_entry <= 1'($urandom);
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    adjacency_entry <= bit_value;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (rows_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [VCOUNT_W-1:0] count);
    wait_drained();
    config_write <= 1'b1;
    config_data  <= count;
    @(posedge clk);
    config_write <= 1'b0;
    side = (count == 0) ? 1 : ((count > MAX_VERTICES) ? MAX_VERTICES : int'(count));
  endtask

  task automatic send_matrix(input fill_t fill);
    logic bits [MAX_VERTICES*MAX_VERTICES];
    int   density;
    int   hole;
    density = $urandom_range(100);
    hole    = $urandom_range(side * side - 1);
    for (int k = 0; k < side * side; k++) begin
      case (fill)
        FILL_EMPTY:        bits[k] = 1'b0;
        FILL_ONES:         bits[k] = 1'b1;
        FILL_ONES_BUT_ONE: bits[k] = (k != hole);
        default:           bits[k] = ($urandom_range(99) < density);
      endcase
    end
    if (fill == FILL_SYMMETRIC) begin
      for (int i = 0; i < side; i++)
        for (int j = i + 1; j < side; j++)
          bits[i*side+j] = bits[j*side+i];
    end
    for (int k = 0; k < side * side; k++) offer_entry(bits[k]);
  endtask

  // Mostly small graphs, with the odd full-size one and out-of-range counts.
  function automatic logic [VCOUNT_W-1:0] pick_vertex_count();
    int roll;
    roll = $urandom_range(19);
    if (roll < 12) return VCOUNT_W'($urandom_range(1, 4));
    if (roll < 15) return VCOUNT_W'($urandom_range(5, 7));
    if (roll < 17) return VCOUNT_W'(MAX_VERTICES);
    if (roll == 17) return '0;
    return VCOUNT_W'($urandom_range(MAX_VERTICES + 1, 15));
  endfunction

  function automatic fill_t pick_fill();
    int roll;
    roll = $urandom_range(9);
    if (roll < 5) return FILL_RANDOM;
    if (roll < 7) return FILL_SYMMETRIC;
    if (roll == 7) return FILL_EMPTY;
    if (roll == 8) return FILL_ONES;
    return FILL_ONES_BUT_ONE;
  endfunction

  initial begin : stimulus
    int phase_items;
    int roll;
    int partial;
    rst             = 1'b1;
    config_write    = 1'b0;
    config_data     = '0;
    in_valid        = 1'b0;
    adjacency_entry = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_pct   = 30;
    stall_pct = 30;
    // A partial load at the reset size, then abandoned by a zero count,
    // which behaves as a single vertex.
    offer_entry(1'b1);
    offer_entry(1'b0);
    offer_entry(1'b1);
    write_vertex_count(4'd0);
    offer_entry(1'b1);  // self-loop
    offer_entry(1'b0);  // empty graph
    write_vertex_count(4'd2);
    offer_entry(1'b0); offer_entry(1'b1); offer_entry(1'b1); offer_entry(1'b0);
    offer_entry(1'b1); offer_entry(1'b1); offer_entry(1'b0); offer_entry(1'b1);
    // One loaded bit must be dropped by the next write.
    offer_entry(1'b1);
    write_vertex_count(4'd3);
    offer_entry(1'b1); offer_entry(1'b0); offer_entry(1'b1);
    offer_entry(1'b0); offer_entry(1'b0); offer_entry(1'b1);
    offer_entry(1'b1); offer_entry(1'b1); offer_entry(1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      gap_pct     = GAP_PLAN[phase];
      stall_pct   = STALL_PLAN[phase];
      phase_items = 0;
      if (phase == 2) begin
        // The receiver holds off while back-to-back matrices keep arriving.
        write_vertex_count(4'd2);
        pressure_req <= ~pressure_req;
        repeat (5) send_matrix(FILL_RANDOM);
        phase_items += 20;
      end
      while (phase_items < PHASE_ITEMS) begin
        roll = $urandom_range(9);
        if (roll < 3) begin
          write_vertex_count(pick_vertex_count());
        end else if (roll == 3 && side > 1) begin
          partial = $urandom_range(1, side * side - 1);
          repeat (partial) offer_entry(1'($urandom));
          write_vertex_count(pick_vertex_count());
        end
        send_matrix(pick_fill());
        phase_items += side * side;
      end
    end

    // A full-size graph with nearly every entry set; it is directed unless the cleared entry is on the diagonal.
    write_vertex_count(4'd15);
    send_matrix(FILL_ONES_BUT_ONE);
    wait_drained();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/adjinc_pkg.sv
src/adjinc_ram.sv
src/adjinc_ctrl.sv
src/adjinc_dp.sv
src/adjacency_to_incidence_edges.sv
src/adjinc_chk.sv
verif/adjacency_to_incidence_edges_checker.sv
verif/adjacency_to_incidence_edges_tb.sv
